FILE: hw/rtl/text_to_integer_parser_unit_macros.svh
// assertion macros shared by the parser modules
`ifndef TEXT_TO_INTEGER_PARSER_UNIT_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TIPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TIPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tipu_pkg.sv
// shared types, codes and constants of the text to integer parser
package tipu_pkg;

    localparam int VALUE_BYTES     = 8;
    localparam int VALUE_W         = VALUE_BYTES * 8;
    localparam int HEX_DIGITS_MAX  = VALUE_BYTES * 2;
    localparam int DEC_MAX_SIGNED  = 19;
    localparam int DEC_MAX_UNSIGN  = 20;
    localparam int DCNT_W          = 5;
    localparam int LEN_W           = 6;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 3;

    // configuration register indexes
    localparam int REG_SIGNED_MODE = 0;

    // ascii codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // keyword spellings, lower case
    localparam logic [7:0] WORD_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
    localparam logic [7:0] WORD_FALSE [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_LONG     = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_FRACTION = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PATH_UNDECIDED = 2'd0,
        PATH_DECIMAL   = 2'd1,
        PATH_HEX       = 2'd2
    } t_path;

    // classified character item passed from front to back
    typedef struct packed {
        logic       has_char;
        logic       last;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] dig;
        logic       is_minus;
        logic       is_dot;
        logic       is_zero;
        logic       is_one;
        logic       is_x;
        logic [3:0] kw_t;
        logic [4:0] kw_f;
    } t_item;

endpackage

FILE: hw/rtl/tipu_front.sv
// front end: takes character items, classifies them, registers them
module tipu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char,
    input  logic            i_has_char,
    input  logic            i_last,
    output logic            o_valid,
    input  logic            i_ready,
    output tipu_pkg::t_item o_item
);
    import tipu_pkg::*;

    logic       r_valid;
    t_item      r_item;
    t_item      n_item;
    logic [7:0] low;
    logic       keep;

    // character classification
    always_comb begin
        low = ((i_char >= CH_UA) && (i_char <= CH_UZ)) ? (i_char + CASE_OFS) : i_char;
        n_item.has_char = i_has_char;
        n_item.last     = i_last;
        n_item.is_dec   = (i_char >= CH_0) && (i_char <= CH_9);
        n_item.is_hex   = n_item.is_dec || ((low >= CH_LA) && (low <= CH_LF));
        n_item.dig      = n_item.is_dec ? 4'(i_char - CH_0) : 4'(low - CH_LA + 8'd10);
        n_item.is_minus = (i_char == CH_MINUS);
        n_item.is_dot   = (i_char == CH_DOT);
        n_item.is_zero  = (i_char == CH_0);
        n_item.is_one   = (i_char == CH_1);
        n_item.is_x     = (i_char == CH_LX) || (i_char == CH_UX);
        for (int k = 0; k < 4; k++) begin
            n_item.kw_t[k] = (low == WORD_TRUE[k]);
        end
        for (int k = 0; k < 5; k++) begin
            n_item.kw_f[k] = (low == WORD_FALSE[k]);
        end
    end

    // items with neither character nor end mark are dropped
    assign keep    = i_has_char || i_last;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // item register, valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready && keep) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // item register, payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: hw/rtl/tipu_queue.sv
// short item queue between front and back
`include "text_to_integer_parser_unit_macros.svh"

module tipu_queue #(
    parameter int DEPTH = tipu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tipu_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output tipu_pkg::t_item o_item
);
    import tipu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `TIPU_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `TIPU_ASSERT_NOW(a_empty_ptrs, r_count == '0, r_wr_ptr == r_rd_ptr, "empty queue with apart pointers")
    `TIPU_ASSERT_NEXT(a_push_count, push && !pop, r_count == $past(r_count) + 1'b1, "count missed a push")

endmodule

FILE: hw/rtl/tipu_back.sv
// back end: accumulates digits, tracks keywords and errors, forms results
`include "text_to_integer_parser_unit_macros.svh"

module tipu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_mode,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  tipu_pkg::t_item              i_q_item,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [tipu_pkg::VALUE_W-1:0] o_m_value,
    output logic [tipu_pkg::STATUS_W-1:0] o_m_status
);
    import tipu_pkg::*;

    localparam logic [1:0] KW_BOTH = 2'b11;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               ovf;
        logic [DCNT_W-1:0]  dcnt;
        logic [LEN_W-1:0]   len;
        logic               neg;
        t_path              path;
        t_status            err;
        logic [1:0]         kw;
        logic               c0_one;
    } t_snap;

    // token state
    logic [VALUE_W-1:0] r_acc;
    logic               r_ovf;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [LEN_W-1:0]   r_len;
    logic               r_neg;
    t_path              r_path;
    t_status            r_err;
    logic [1:0]         r_kw;
    logic               r_c0_zero;
    logic               r_c0_one;
    logic               r_c1_x;

    // next values
    logic [VALUE_W-1:0] n_acc;
    logic               n_ovf;
    logic [DCNT_W-1:0]  n_dcnt;
    logic [LEN_W-1:0]   n_len;
    logic               n_neg;
    t_path              n_path;
    t_status            n_err;
    logic [1:0]         n_kw;
    logic               n_c0_zero;
    logic               n_c0_one;
    logic               n_c1_x;

    logic               go_hex;
    logic [VALUE_W+3:0] wide;
    logic [7:0]         kw_f8;
    logic               q_pop;

    // finish stage and output register
    logic               r_snap_valid;
    t_snap              r_snap;
    t_snap              n_snap;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_val;
    t_status            r_out_st;
    logic [VALUE_W-1:0] res_val;
    t_status            res_st;
    logic               out_free;
    logic               snap_free;
    logic               big;

    assign out_free  = !r_out_valid || i_m_ready;
    assign snap_free = !r_snap_valid || out_free;
    assign o_q_ready = !i_q_item.last || snap_free;
    assign q_pop     = i_q_valid && o_q_ready;

    // per-character update of the token state
    always_comb begin
        go_hex    = i_q_item.has_char && (r_len == LEN_W'(2)) && r_c0_zero && r_c1_x;
        n_acc     = go_hex ? '0 : r_acc;
        n_ovf     = go_hex ? 1'b0 : r_ovf;
        n_dcnt    = go_hex ? '0 : r_dcnt;
        n_neg     = go_hex ? 1'b0 : r_neg;
        n_err     = go_hex ? ST_OK : r_err;
        n_path    = r_path;
        n_kw      = r_kw;
        n_c0_zero = r_c0_zero;
        n_c0_one  = r_c0_one;
        n_c1_x    = r_c1_x;
        n_len     = r_len;
        kw_f8     = {3'b000, i_q_item.kw_f};
        wide      = {1'b0, n_acc, 3'b000} + {3'b000, n_acc, 1'b0}
                    + {{VALUE_W{1'b0}}, i_q_item.dig};
        if (i_q_item.has_char) begin
            // keyword candidates
            if ((r_len >= LEN_W'(4)) || !i_q_item.kw_t[r_len[1:0]]) begin
                n_kw[0] = 1'b0;
            end
            if ((r_len >= LEN_W'(5)) || !kw_f8[r_len[2:0]]) begin
                n_kw[1] = 1'b0;
            end
            // prefix flags
            if (r_len == '0) begin
                n_c0_zero = i_q_item.is_zero;
                n_c0_one  = i_q_item.is_one;
            end
            if (r_len == LEN_W'(1)) begin
                n_c1_x = i_q_item.is_x;
            end
            // path decided at the third character
            if (r_len == LEN_W'(2)) begin
                n_path = go_hex ? PATH_HEX : PATH_DECIMAL;
            end
            if (n_path == PATH_HEX) begin
                if (i_q_item.is_hex) begin
                    n_acc = {n_acc[VALUE_W-5:0], i_q_item.dig};
                    if (n_dcnt != '1) begin
                        n_dcnt = n_dcnt + 1'b1;
                    end
                end else if (n_err == ST_OK) begin
                    n_err = ST_INVALID;
                end
            end else begin
                if ((r_len == '0) && i_mode && i_q_item.is_minus) begin
                    n_neg = 1'b1;
                end else if (i_q_item.is_dec) begin
                    n_ovf = n_ovf || (wide[VALUE_W+3:VALUE_W] != '0);
                    n_acc = wide[VALUE_W-1:0];
                    if (n_dcnt != '1) begin
                        n_dcnt = n_dcnt + 1'b1;
                    end
                end else if (n_err == ST_OK) begin
                    n_err = i_q_item.is_dot ? ST_FRACTION : ST_INVALID;
                end
            end
            if (r_len != '1) begin
                n_len = r_len + 1'b1;
            end
        end
        n_snap.acc    = n_acc;
        n_snap.ovf    = n_ovf;
        n_snap.dcnt   = n_dcnt;
        n_snap.len    = n_len;
        n_snap.neg    = n_neg;
        n_snap.path   = n_path;
        n_snap.err    = n_err;
        n_snap.kw     = n_kw;
        n_snap.c0_one = n_c0_one;
    end

    // token state registers, cleared after the closing item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_ovf     <= 1'b0;
            r_dcnt    <= '0;
            r_len     <= '0;
            r_neg     <= 1'b0;
            r_path    <= PATH_UNDECIDED;
            r_err     <= ST_OK;
            r_kw      <= KW_BOTH;
            r_c0_zero <= 1'b0;
            r_c0_one  <= 1'b0;
            r_c1_x    <= 1'b0;
        end else if (q_pop) begin
            if (i_q_item.last) begin
                r_acc     <= '0;
                r_ovf     <= 1'b0;
                r_dcnt    <= '0;
                r_len     <= '0;
                r_neg     <= 1'b0;
                r_path    <= PATH_UNDECIDED;
                r_err     <= ST_OK;
                r_kw      <= KW_BOTH;
                r_c0_zero <= 1'b0;
                r_c0_one  <= 1'b0;
                r_c1_x    <= 1'b0;
            end else begin
                r_acc     <= n_acc;
                r_ovf     <= n_ovf;
                r_dcnt    <= n_dcnt;
                r_len     <= n_len;
                r_neg     <= n_neg;
                r_path    <= n_path;
                r_err     <= n_err;
                r_kw      <= n_kw;
                r_c0_zero <= n_c0_zero;
                r_c0_one  <= n_c0_one;
                r_c1_x    <= n_c1_x;
            end
        end
    end

    // closed token snapshot, valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (q_pop && i_q_item.last) begin
            r_snap_valid <= 1'b1;
        end else if (out_free) begin
            r_snap_valid <= 1'b0;
        end
    end

    // closed token snapshot, payload
    always_ff @(posedge i_clk) begin
        if (q_pop && i_q_item.last) begin
            r_snap <= n_snap;
        end
    end

    // result decision in priority order
    always_comb begin
        res_val = '0;
        res_st  = ST_OK;
        big     = r_snap.neg ? (r_snap.acc[VALUE_W-1] && (r_snap.acc[VALUE_W-2:0] != '0))
                             : r_snap.acc[VALUE_W-1];
        if (r_snap.kw[0] && (r_snap.len == LEN_W'(4))) begin
            res_val = VALUE_W'(1);
        end else if (r_snap.kw[1] && (r_snap.len == LEN_W'(5))) begin
            res_val = '0;
        end else if (r_snap.len == '0) begin
            res_st = ST_EMPTY;
        end else if (r_snap.path == PATH_HEX) begin
            if (r_snap.len > LEN_W'(HEX_DIGITS_MAX + 2)) begin
                res_st = ST_LONG;
            end else if (r_snap.err != ST_OK) begin
                res_st = r_snap.err;
            end else begin
                res_val = r_snap.acc;
            end
        end else if (r_snap.err != ST_OK) begin
            res_st = r_snap.err;
        end else if (!i_mode && r_snap.neg) begin
            res_st = ST_INVALID;
        end else if (r_snap.dcnt == '0) begin
            res_st = ST_EMPTY;
        end else if (i_mode) begin
            if (r_snap.dcnt > DCNT_W'(DEC_MAX_SIGNED)) begin
                res_st = ST_LONG;
            end else if (r_snap.ovf || big) begin
                res_st = ST_OVERFLOW;
            end else begin
                res_val = r_snap.neg ? (~r_snap.acc + 1'b1) : r_snap.acc;
            end
        end else begin
            if (r_snap.dcnt > DCNT_W'(DEC_MAX_UNSIGN)) begin
                res_st = ST_LONG;
            end else if ((r_snap.dcnt == DCNT_W'(DEC_MAX_UNSIGN))
                         && (!r_snap.c0_one || !r_snap.acc[VALUE_W-1])) begin
                res_st = ST_OVERFLOW;
            end else begin
                res_val = r_snap.acc;
            end
        end
    end

    // output register, valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_snap_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register, payload
    always_ff @(posedge i_clk) begin
        if (r_snap_valid && out_free) begin
            r_out_val <= res_val;
            r_out_st  <= res_st;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_value  = r_out_val;
    assign o_m_status = r_out_st;

    `TIPU_ASSERT_NOW(a_err_zero, r_out_valid && (r_out_st != ST_OK), r_out_val == '0, "error nonzero")
    `TIPU_ASSERT_NOW(a_hex_len, r_path == PATH_HEX, r_len >= LEN_W'(3), "early hex path")
    `TIPU_ASSERT_NEXT(a_clear_after_last, q_pop && i_q_item.last, (r_len == '0) && (r_kw == KW_BOTH), "kept")
    `TIPU_ASSERT_NEXT(a_snap_hold, r_snap_valid && !out_free, r_snap == $past(r_snap), "snapshot lost")

endmodule

FILE: hw/rtl/text_to_integer_parser_unit.sv
// top level: text to integer parser with stream ports and register port
// a closing item passes the front item register, a queue entry, the snapshot and the output register
// throughput: one item per cycle unless the result side stalls, set by the single shift-add of the back end
// result register and snapshot stage let input run on while a result waits
// reset: synchronous active low, empties front, queue and back, signed_mode to 1
// no memory clearing pass after reset
module text_to_integer_parser_unit #(
    parameter int QUEUE_DEPTH = tipu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // character items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] character
    input  logic                          s_axis_tuser,  // [0] has_char
    input  logic                          s_axis_tlast,
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tipu_pkg::VALUE_W-1:0]  m_axis_tdata,  // [63:0] value
    output logic [tipu_pkg::STATUS_W-1:0] m_axis_tuser,  // [2:0] status
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tipu_pkg::*;

    logic  r_signed_mode;
    logic  cfg_hit;
    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    // register port
    assign pready  = 1'b1;
    assign cfg_hit = (32'(paddr[2]) == 32'(REG_SIGNED_MODE));
    assign prdata  = cfg_hit ? {31'b0, r_signed_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_signed_mode <= pwdata[0];
        end
    end

    tipu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_char     (s_axis_tdata),
        .i_has_char (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_item     (f_item)
    );

    tipu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    tipu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_signed_mode),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_item   (q_item),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_value  (m_axis_tdata),
        .o_m_status (m_axis_tuser)
    );

endmodule
